### rtl/core/spf_pkg.sv
package spf_pkg;

   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] END_BYTE   = 8'h55;
   localparam logic [10:0] OVERHEAD  = 11'd7;

   // Depth of the job queue between front and back.
   localparam int JOB_DEPTH   = 4;
   localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
   localparam int JOB_COUNT_W = $clog2(JOB_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  cmd;
      logic [10:0] payload_len;
      logic [7:0]  data_byte;
      logic        has_data;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

   // One classified item: which byte groups it emits and their contents.
   typedef struct packed {
      logic       hdr;
      logic       has;
      logic       tail;
      logic [7:0] cmd;
      logic [7:0] len_lo;
      logic [7:0] len_hi;
      logic [7:0] seq;
      logic [7:0] data;
      logic [7:0] chk;
   } job_type;

   // Byte positions within the output of one job.
   typedef enum logic [2:0] {
      SLOT_START = 3'd0,
      SLOT_CMD   = 3'd1,
      SLOT_LEN_LO = 3'd2,
      SLOT_LEN_HI = 3'd3,
      SLOT_SEQ   = 3'd4,
      SLOT_DATA  = 3'd5,
      SLOT_CHK   = 3'd6,
      SLOT_END   = 3'd7
   } slot_type;

endpackage

### rtl/core/serial_packet_framer.sv
// The first byte an item causes passes through the job queue and then the output
// register before it appears on rsp_item, when the result side is not stalled.
// Rate: one frame byte per cycle while the consumer keeps popping. A payload item gives
// its data byte, an opening item five header bytes more and a closing item two more.
// Reset clears the packet state, the sequence number, the job queue and the output stage.
module serial_packet_framer #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  spf_pkg::req_type  req_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output spf_pkg::rsp_type  rsp_item
);

   // The front classifies each item as it arrives: it tracks whether a packet is
   // open or being dropped, stamps the sequence number and keeps the running
   // checksum. Each item that yields output becomes one job in a short queue.
   // The back walks a job's present byte slots into the output register one per cycle
   // when it is free, so a stalled consumer never blocks the front until the queue fills.

   logic              accept;
   logic              job_push;
   spf_pkg::job_type  front_job;
   logic              job_valid;
   logic              job_pop;
   spf_pkg::job_type  head_job;

   assign accept = req_push && !req_full;

   spf_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_item),
      .job_push (job_push),
      .job      (front_job)
   );

   // Items that yield no output (dropped packets) are still accepted only while
   // the queue has room, which keeps the full flag a plain queue status.
   spf_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (req_full),
      .valid    (job_valid),
      .head_job (head_job),
      .pop      (job_pop)
   );

   spf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/core/spf_front.sv
module spf_front #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  spf_pkg::req_type  item,
   output logic              job_push,
   output spf_pkg::job_type  job
);

   logic       in_packet_ff, in_packet_in;
   logic       dropping_ff, dropping_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] xor_ff, xor_in;

   logic [10:0] total;
   logic [7:0]  x_hdr;
   logic [7:0]  x_data;
   logic        oversize;

   assign total    = item.payload_len + spf_pkg::OVERHEAD;
   assign oversize = item.payload_len > 11'(MAX_PAYLOAD);

   always_comb begin
      in_packet_in = in_packet_ff;
      dropping_in  = dropping_ff;
      seq_in       = seq_ff;
      xor_in       = xor_ff;
      job_push     = 1'b0;
      x_hdr        = xor_ff;
      x_data       = xor_ff;

      job.hdr    = 1'b0;
      job.has    = item.has_data;
      job.tail   = item.last_item;
      job.cmd    = item.cmd;
      job.len_lo = total[7:0];
      job.len_hi = {5'd0, total[10:8]};
      job.seq    = seq_ff;
      job.data   = item.data_byte;
      job.chk    = 8'd0;

      if (!in_packet_ff) begin
         job.hdr = 1'b1;
         x_hdr   = item.cmd ^ total[7:0] ^ {5'd0, total[10:8]} ^ seq_ff;
      end
      x_data  = item.has_data ? (x_hdr ^ item.data_byte) : x_hdr;
      job.chk = x_data;

      if (accept) begin
         priority if (!in_packet_ff && oversize) begin
            in_packet_in = !item.last_item;
            dropping_in  = !item.last_item;
         end else if (in_packet_ff && dropping_ff) begin
            if (item.last_item) begin
               in_packet_in = 1'b0;
               dropping_in  = 1'b0;
            end
         end else begin
            if (!in_packet_ff) begin
               seq_in = seq_ff + 8'd1;
            end
            job_push = job.hdr || item.has_data || item.last_item;
            dropping_in = 1'b0;
            if (item.last_item) begin
               in_packet_in = 1'b0;
               xor_in       = 8'd0;
            end else begin
               in_packet_in = 1'b1;
               xor_in       = x_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         dropping_ff  <= 1'b0;
         seq_ff       <= 8'd0;
         xor_ff       <= 8'd0;
      end else begin
         in_packet_ff <= in_packet_in;
         dropping_ff  <= dropping_in;
         seq_ff       <= seq_in;
         xor_ff       <= xor_in;
      end
   end

endmodule

### rtl/core/spf_job_queue.sv
module spf_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spf_pkg::job_type  push_job,
   output logic              full,
   output logic              valid,
   output spf_pkg::job_type  head_job,
   input  logic              pop
);

   spf_pkg::job_type mem [spf_pkg::JOB_DEPTH];

   logic [spf_pkg::JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [spf_pkg::JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [spf_pkg::JOB_COUNT_W-1:0] count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full     = count_ff == spf_pkg::JOB_COUNT_W'(spf_pkg::JOB_DEPTH);
   assign valid    = count_ff != '0;
   assign head_job = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + spf_pkg::JOB_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + spf_pkg::JOB_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + spf_pkg::JOB_COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - spf_pkg::JOB_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/spf_back.sv
module spf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  spf_pkg::job_type  job,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output spf_pkg::rsp_type  rsp_item
);

   logic [2:0]        pos_ff, pos_in;
   logic              out_valid_ff, out_valid_in;
   spf_pkg::rsp_type  out_ff, out_in;

   logic [7:0]        mask;
   logic [7:0]        ge_mask;
   logic [7:0]        masked;
   logic [7:0]        rest;
   logic [2:0]        slot;
   logic              load;
   spf_pkg::rsp_type  byte_sel;

   assign mask    = {job.tail, job.tail, job.has, {5{job.hdr}}};
   assign ge_mask = 8'hFF << pos_ff;
   assign masked  = mask & ge_mask;
   assign rest    = masked & (masked - 8'd1);
   assign load    = job_valid && (!out_valid_ff || rsp_pop);
   assign job_pop = load && (rest == 8'd0);

   always_comb begin
      slot = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (masked[i]) begin
            slot = 3'(i);
         end
      end
   end

   always_comb begin
      byte_sel.frame_end = 1'b0;
      unique case (spf_pkg::slot_type'(slot))
         spf_pkg::SLOT_START:  byte_sel.frame_byte = spf_pkg::START_BYTE;
         spf_pkg::SLOT_CMD:    byte_sel.frame_byte = job.cmd;
         spf_pkg::SLOT_LEN_LO: byte_sel.frame_byte = job.len_lo;
         spf_pkg::SLOT_LEN_HI: byte_sel.frame_byte = job.len_hi;
         spf_pkg::SLOT_SEQ:    byte_sel.frame_byte = job.seq;
         spf_pkg::SLOT_DATA:   byte_sel.frame_byte = job.data;
         spf_pkg::SLOT_CHK:    byte_sel.frame_byte = job.chk;
         spf_pkg::SLOT_END: begin
            byte_sel.frame_byte = spf_pkg::END_BYTE;
            byte_sel.frame_end  = 1'b1;
         end
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (load) begin
         out_in       = byte_sel;
         out_valid_in = 1'b1;
         pos_in       = job_pop ? 3'd0 : slot + 3'd1;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
